/* rtl/core/fstv_pkg.sv */
`timescale 1ns / 1ps

package fstv_pkg;

    // Nesting capacity below the root; the stack holds one more pair for the root.
    localparam int MAX_NEST   = 16;
    localparam int NEST_DEPTH = MAX_NEST + 1;
    localparam int ADDR_W     = $clog2(NEST_DEPTH);
    localparam int LVL_W      = $clog2(NEST_DEPTH + 1);
    localparam int DL_W       = 5;
    localparam int LIM_W      = (LVL_W > DL_W) ? LVL_W : DL_W;
    localparam int CFG_IDX_W  = 8;

    localparam logic [31:0] ENTRY_BYTES = 32'd12;
    localparam logic [7:0]  TYPE_FILE   = 8'd0;
    localparam logic [7:0]  TYPE_DIR    = 8'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WORD_OFFSETS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT  = 8'd3;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_IMAGE_SMALL  = 4'd1,
        ST_ROOT_NOT_DIR = 4'd2,
        ST_COUNT_ZERO   = 4'd3,
        ST_COUNT_LIMIT  = 4'd4,
        ST_COUNT_IMAGE  = 4'd5,
        ST_BAD_TYPE     = 4'd6,
        ST_NAME_OUTSIDE = 4'd7,
        ST_BAD_RANGE    = 4'd8,
        ST_TOO_DEEP     = 4'd9,
        ST_IGNORED      = 4'd10
    } fstv_status_t;

    typedef struct packed {
        logic              word_offsets;
        logic [31:0]       image_size;
        logic [31:0]       entry_limit;
        logic [DL_W-1:0]   depth_limit;
    } fstv_cfg_t;

    // Stack pair: directory index in the high half, subtree end in the low half
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [63:0]       wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } fstv_mem_req_t;

endpackage

/* rtl/core/fstv_stack_ram.sv */
`timescale 1ns / 1ps

module fstv_stack_ram
(
    input  logic                  clk,
    input  fstv_pkg::fstv_mem_req_t req,
    output logic [63:0]           rdata
);

    logic [63:0] mem [fstv_pkg::NEST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

/* rtl/core/fstv_engine.sv */
`timescale 1ns / 1ps

module fstv_engine
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  fstv_pkg::fstv_cfg_t       cfg,
    // input word
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      start_of_table,
    input  logic [7:0]                type_byte,
    input  logic [23:0]               name_pos,
    input  logic [31:0]               word_a,
    input  logic [31:0]               word_b,
    // result word
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [31:0]               entry_index,
    output logic [31:0]               parent_index,
    output logic                      is_dir,
    output logic [33:0]               file_offset,
    output logic [31:0]               size_or_end,
    output fstv_pkg::fstv_status_t    status,
    output logic                      last,
    // stack memory
    output fstv_pkg::fstv_mem_req_t   mem_req,
    input  logic [63:0]               mem_rdata
);

    typedef enum logic [1:0] {S_IDLE, S_WORK, S_POPW} state_t;
    typedef enum logic [1:0] {M_IDLE, M_RUN, M_STOP} mode_t;

    state_t                     state_reg;
    mode_t                      mode_reg;
    logic [31:0]                counter_reg;
    logic [31:0]                total_reg;
    logic [35:0]                tbytes_reg;
    logic [fstv_pkg::LVL_W-1:0] level_reg;
    logic [31:0]                top_idx_reg;
    logic [31:0]                top_end_reg;

    // captured input word
    logic        start_reg;
    logic [7:0]  type_reg;
    logic [23:0] noff_reg;
    logic [31:0] wa_reg;
    logic [31:0] wb_reg;

    logic                   out_valid_reg;
    logic [31:0]            idx_reg;
    logic [31:0]            par_reg;
    logic                   dir_reg;
    logic [33:0]            off_reg;
    logic [31:0]            size_reg;
    fstv_pkg::fstv_status_t status_reg;
    logic                   last_reg;

    logic [31:0]            idx_next;
    logic [31:0]            par_next;
    logic                   dir_next;
    logic [33:0]            off_next;
    logic [31:0]            size_next;
    fstv_pkg::fstv_status_t status_next;
    logic                   last_next;

    logic                       in_take;
    logic                       out_free;
    logic                       res_load;
    logic [35:0]                root_bytes;
    logic [36:0]                str_room;
    fstv_pkg::fstv_status_t     root_code;
    logic                       ignore_item;
    logic                       bad_type;
    logic                       pop;
    logic [fstv_pkg::LIM_W-1:0] dl_ext;
    logic [fstv_pkg::LIM_W-1:0] lim;
    fstv_pkg::fstv_status_t     item_code;
    logic                       is_last;
    logic [33:0]                dec_off;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign res_load = (state_reg == S_WORK) && !pop && out_free;

    always_comb
    begin
        root_bytes = ({4'b0000, wb_reg} << 3) + ({4'b0000, wb_reg} << 2);
        if (cfg.image_size < fstv_pkg::ENTRY_BYTES)
            root_code = fstv_pkg::ST_IMAGE_SMALL;
        else if (type_reg != fstv_pkg::TYPE_DIR)
            root_code = fstv_pkg::ST_ROOT_NOT_DIR;
        else if (wb_reg == 32'd0)
            root_code = fstv_pkg::ST_COUNT_ZERO;
        else if (wb_reg > cfg.entry_limit)
            root_code = fstv_pkg::ST_COUNT_LIMIT;
        else if (root_bytes > {4'b0000, cfg.image_size})
            root_code = fstv_pkg::ST_COUNT_IMAGE;
        else
            root_code = fstv_pkg::ST_OK;

        // string table size from the live image size; negative means no name can fail
        str_room = {5'd0, cfg.image_size} - {1'b0, tbytes_reg};

        ignore_item = (mode_reg != M_RUN) || (level_reg == '0)
                      || (level_reg > fstv_pkg::LVL_W'(fstv_pkg::NEST_DEPTH));
        bad_type    = (type_reg != fstv_pkg::TYPE_FILE) && (type_reg != fstv_pkg::TYPE_DIR);
        pop         = !start_reg && !ignore_item && !bad_type
                      && (level_reg > fstv_pkg::LVL_W'(1)) && (counter_reg >= top_end_reg);

        dl_ext = fstv_pkg::LIM_W'(cfg.depth_limit);
        lim    = (dl_ext > fstv_pkg::LIM_W'(fstv_pkg::MAX_NEST))
                 ? fstv_pkg::LIM_W'(fstv_pkg::MAX_NEST) : dl_ext;

        if (bad_type)
            item_code = fstv_pkg::ST_BAD_TYPE;
        else if (!str_room[36] && ({12'd0, noff_reg} >= str_room[35:0]))
            item_code = fstv_pkg::ST_NAME_OUTSIDE;
        else if ((type_reg == fstv_pkg::TYPE_DIR)
                 && ((wb_reg <= counter_reg) || (wb_reg > top_end_reg)))
            item_code = fstv_pkg::ST_BAD_RANGE;
        else if ((type_reg == fstv_pkg::TYPE_DIR)
                 && (fstv_pkg::LIM_W'(level_reg) > lim))
            item_code = fstv_pkg::ST_TOO_DEEP;
        else
            item_code = fstv_pkg::ST_OK;

        is_last = ({1'b0, counter_reg} + 33'd1) >= {1'b0, total_reg};
        dec_off = cfg.word_offsets ? {wa_reg, 2'b00} : {2'b00, wa_reg};
    end

    // result word; errors and ignored words leave everything but index and code at 0
    always_comb
    begin
        idx_next    = '0;
        par_next    = '0;
        dir_next    = 1'b0;
        off_next    = '0;
        size_next   = '0;
        last_next   = 1'b0;
        status_next = fstv_pkg::ST_IGNORED;
        if (start_reg)
        begin
            status_next = root_code;
            if (root_code == fstv_pkg::ST_OK)
            begin
                dir_next  = 1'b1;
                size_next = wb_reg;
                last_next = (wb_reg == 32'd1);
            end
        end
        else if (!ignore_item)
        begin
            status_next = item_code;
            idx_next    = counter_reg;
            if (item_code == fstv_pkg::ST_OK)
            begin
                par_next  = top_idx_reg;
                size_next = wb_reg;
                last_next = is_last;
                if (type_reg == fstv_pkg::TYPE_DIR)
                    dir_next = 1'b1;
                else
                    off_next = dec_off;
            end
        end
    end

    // stack access: root write, directory push, or read of the pair under the top
    always_comb
    begin
        mem_req = '0;
        if (state_reg == S_WORK)
        begin
            if (start_reg)
            begin
                mem_req.we    = out_free && (root_code == fstv_pkg::ST_OK);
                mem_req.waddr = '0;
                mem_req.wdata = {32'd0, wb_reg};
            end
            else if (pop)
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = fstv_pkg::ADDR_W'(level_reg - fstv_pkg::LVL_W'(2));
            end
            else
            begin
                mem_req.we    = out_free && !ignore_item && (item_code == fstv_pkg::ST_OK)
                                && (type_reg == fstv_pkg::TYPE_DIR);
                mem_req.waddr = fstv_pkg::ADDR_W'(level_reg);
                mem_req.wdata = {counter_reg, wb_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_IDLE;
            counter_reg   <= '0;
            total_reg     <= '0;
            tbytes_reg    <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        start_reg <= start_of_table;
                        type_reg  <= type_byte;
                        noff_reg  <= name_pos;
                        wa_reg    <= word_a;
                        wb_reg    <= word_b;
                        state_reg <= S_WORK;
                    end
                end
                S_WORK:
                begin
                    if (pop)
                    begin
                        level_reg <= level_reg - fstv_pkg::LVL_W'(1);
                        state_reg <= S_POPW;
                    end
                    else if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (start_reg)
                        begin
                            if (root_code == fstv_pkg::ST_OK)
                            begin
                                total_reg   <= wb_reg;
                                tbytes_reg  <= root_bytes;
                                level_reg   <= fstv_pkg::LVL_W'(1);
                                top_idx_reg <= '0;
                                top_end_reg <= wb_reg;
                                counter_reg <= 32'd1;
                                mode_reg    <= (wb_reg == 32'd1) ? M_STOP : M_RUN;
                            end
                            else
                            begin
                                mode_reg <= M_STOP;
                            end
                        end
                        else if (!ignore_item)
                        begin
                            if (item_code != fstv_pkg::ST_OK)
                            begin
                                mode_reg <= M_STOP;
                            end
                            else
                            begin
                                counter_reg <= counter_reg + 32'd1;
                                if (is_last)
                                    mode_reg <= M_STOP;
                                if (type_reg == fstv_pkg::TYPE_DIR)
                                begin
                                    level_reg   <= level_reg + fstv_pkg::LVL_W'(1);
                                    top_idx_reg <= counter_reg;
                                    top_end_reg <= wb_reg;
                                end
                            end
                        end
                    end
                end
                S_POPW:
                begin
                    // new top arrives from the stack memory
                    top_idx_reg <= mem_rdata[63:32];
                    top_end_reg <= mem_rdata[31:0];
                    state_reg   <= S_WORK;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            idx_reg    <= idx_next;
            par_reg    <= par_next;
            dir_reg    <= dir_next;
            off_reg    <= off_next;
            size_reg   <= size_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign entry_index  = idx_reg;
    assign parent_index = par_reg;
    assign is_dir       = dir_reg;
    assign file_offset  = off_reg;
    assign size_or_end  = size_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

/* rtl/core/fs_table_entry_validator.sv */
`timescale 1ns / 1ps

// Channel   Handshake               Word
// in        in_valid / in_stall     start_of_table, type_byte, name_pos, word_a, word_b
// out       out_valid / out_stall   entry_index, parent_index, is_dir, file_offset,
//                                   size_or_end, status, last
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An entry is captured (S_IDLE), then checked and its result made (S_WORK); each
// enclosing directory popped first adds a read of the nesting stack memory (S_WORK)
// and a wait for its data (S_POPW). in_stall holds off the next word meanwhile.
// Pops never outnumber pushes, so a long table pops at most once per directory.
// Reset clears the control state and loads the register defaults; the stack memory
// is not cleared, since it is never read above the current level.
// A stalled result sits in the output register; the next word is still captured,
// and its result waits until the output register frees.
// cfg_ready is always high; writes to indexes above REG_DEPTH_LIMIT are dropped.

module fs_table_entry_validator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              start_of_table,
    input  logic [7:0]                        type_byte,
    input  logic [23:0]                       name_pos,
    input  logic [31:0]                       word_a,
    input  logic [31:0]                       word_b,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [31:0]                       entry_index,
    output logic [31:0]                       parent_index,
    output logic                              is_dir,
    output logic [33:0]                       file_offset,
    output logic [31:0]                       size_or_end,
    output logic [3:0]                        status,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fstv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);

    fstv_pkg::fstv_cfg_t      cfg_reg;
    fstv_pkg::fstv_mem_req_t  mem_req;
    fstv_pkg::fstv_status_t   status_int;
    logic [63:0]              mem_rdata;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.word_offsets <= 1'b0;
            cfg_reg.image_size   <= 32'd0;
            cfg_reg.entry_limit  <= 32'hFFFF_FFFF;
            cfg_reg.depth_limit  <= fstv_pkg::DL_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fstv_pkg::REG_WORD_OFFSETS: cfg_reg.word_offsets <= cfg_data[0];
                fstv_pkg::REG_IMAGE_SIZE:   cfg_reg.image_size   <= cfg_data;
                fstv_pkg::REG_ENTRY_LIMIT:  cfg_reg.entry_limit  <= cfg_data;
                fstv_pkg::REG_DEPTH_LIMIT:  cfg_reg.depth_limit  <= cfg_data[fstv_pkg::DL_W-1:0];
                default: ;
            endcase
        end
    end

    fstv_engine u_engine
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_of_table (start_of_table),
        .type_byte      (type_byte),
        .name_pos       (name_pos),
        .word_a         (word_a),
        .word_b         (word_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_index    (entry_index),
        .parent_index   (parent_index),
        .is_dir         (is_dir),
        .file_offset    (file_offset),
        .size_or_end    (size_or_end),
        .status         (status_int),
        .last           (last),
        .mem_req        (mem_req),
        .mem_rdata      (mem_rdata)
    );

    fstv_stack_ram u_stack
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign status = status_int;

endmodule
